### hw/rtl/mmc_pkg.sv
// ============================================================================
// mmc_pkg: shared constants and types of the Montgomery multiplier
// Digit geometry, configuration register indexes and the link types that
// pass between neighboring cells of the digit chain.
// ============================================================================
package mmc_pkg;

    localparam int DIGITS     = 8;
    localparam int DIGIT_BITS = 4;
    localparam int DATA_W     = 32;
    localparam int NDI_W      = 4;
    localparam int CFG_IDX_W  = 8;
    localparam int VAL_W      = DIGITS * DIGIT_BITS;
    localparam int PROD_W     = 2 * DIGIT_BITS;
    localparam int SUM_W      = 2 * DIGIT_BITS + 1;
    localparam int CARRY_W    = DIGIT_BITS + 1;
    localparam int STEP_W     = $clog2(DIGITS + 1);
    localparam int ITER_W     = $clog2(DIGITS);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODULUS     = 0,
        REG_MOD_INV_DIG = 1
    } t_cfg_reg;

    typedef logic [DIGIT_BITS-1:0] t_digit;

    // token and carry moving up the chain
    typedef struct packed {
        logic               act;
        logic [CARRY_W-1:0] carry;
    } t_link;

    // result digit moving down the chain (shift by one digit)
    typedef struct packed {
        logic   vld;
        t_digit digit;
    } t_dig;

endpackage

### hw/rtl/mmc_if.sv
// ============================================================================
// mmc_if: word channels of the Montgomery multiplier
// Operand channel, product channel and configuration write channel, each
// with valid, ready and payload.
// ============================================================================
interface mmc_in_if;
    import mmc_pkg::*;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] a_value;
    logic [DATA_W-1:0] b_value;
    modport source (output valid, output a_value, output b_value, input ready);
    modport sink   (input valid, input a_value, input b_value, output ready);
endinterface

interface mmc_out_if;
    import mmc_pkg::*;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] product;
    modport source (output valid, output product, input ready);
    modport sink   (input valid, input product, output ready);
endinterface

interface mmc_cfg_if;
    import mmc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/montgomery_multiply_cios_top.sv
// ============================================================================
// montgomery_multiply_cios_top: Montgomery product a*b*R^-1 mod n (CIOS)
// Steps: a prep step, a pass of the digit chain per digit of b, and a
//   final-subtract step that registers the result word.
// Operand words are taken only while idle, one at a time; the chain carries a
//   single token that visits DIGITS cells plus the top digit per digit of b.
// Reset: control and output valid cleared; modulus = all ones, n' = 1.
// ============================================================================
module montgomery_multiply_cios_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mmc_in_if.sink       i_in,
    mmc_out_if.source    o_out,
    mmc_cfg_if.sink      i_cfg
);
    import mmc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_RUN,
        S_FIN
    } t_state;

    // ------------------------------------------------------------------
    // Configuration registers; writes land only while the block is idle.
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] r_modulus;
    logic [NDI_W-1:0]  r_nd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= '1;
            r_nd      <= NDI_W'(1);
        end else if (i_cfg.valid && i_cfg.ready) begin
            if (i_cfg.index == REG_MODULUS) begin
                r_modulus <= i_cfg.data;
            end else if (i_cfg.index == REG_MOD_INV_DIG) begin
                r_nd <= i_cfg.data[NDI_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Control and per-item state
    // ------------------------------------------------------------------
    t_state             r_state;
    logic [STEP_W-1:0]  r_step;
    logic [ITER_W-1:0]  r_iter;
    logic [VAL_W-1:0]   r_b;       // b digits, current digit at the bottom
    t_digit             r_an;      // a[0]*n' mod 2^w
    t_digit             r_m;       // reduction digit for the current pass
    logic [CARRY_W-1:0] r_top;     // digit DIGITS of the running sum
    logic               r_out_valid;
    logic [DATA_W-1:0]  r_product;

    logic               w_accept;
    logic [VAL_W-1:0]   w_a_ext;
    logic [VAL_W-1:0]   w_b_ext;
    logic [VAL_W-1:0]   w_n_ext;
    t_digit             w_nd;
    logic [PROD_W-1:0]  w_an_prod;

    assign w_accept  = i_in.valid && i_in.ready;
    assign w_a_ext   = VAL_W'(i_in.a_value);
    assign w_b_ext   = VAL_W'(i_in.b_value);
    assign w_n_ext   = VAL_W'(r_modulus);
    assign w_nd      = DIGIT_BITS'(r_nd);
    assign w_an_prod = PROD_W'(w_a_ext[DIGIT_BITS-1:0]) * PROD_W'(w_nd);

    // a pending register word goes first, so an operand word never starts
    // in the same cycle as a register write
    assign i_cfg.ready   = (r_state == S_IDLE);
    assign i_in.ready    = (r_state == S_IDLE) && !i_cfg.valid;
    assign o_out.valid   = r_out_valid;
    assign o_out.product = r_product;

    // m = (t0 + a0*b_i)*n' mod 2^w, with a0*n' taken from a register so
    // that no multiply feeds another in the same cycle
    function automatic t_digit calc_m(t_digit t0, t_digit nd, t_digit an, t_digit bd);
        logic [PROD_W-1:0] p_t;
        logic [PROD_W-1:0] p_b;
        p_t = PROD_W'(t0) * PROD_W'(nd);
        p_b = PROD_W'(an) * PROD_W'(bd);
        return DIGIT_BITS'(p_t + p_b);
    endfunction

    // ------------------------------------------------------------------
    // Digit chain: link[j] drives cell j, link[DIGITS] feeds the top digit.
    // dig[j] is the digit handed down into cell j-1's sum register.
    // ------------------------------------------------------------------
    t_link              w_link [0:DIGITS];
    t_dig               w_dig  [1:DIGITS];
    t_digit             w_t    [0:DIGITS-1];
    logic [DIGITS:0]    w_act;
    logic [VAL_W-1:0]   w_t_flat;
    logic [CARRY_W:0]   w_top_sum;

    // start the token at cell 0 on the first step of each pass
    assign w_link[0].act   = (r_state == S_RUN) && (r_step == '0);
    assign w_link[0].carry = '0;

    // top digit: fold the last carry into digit DIGITS, hand low part down
    assign w_top_sum        = (CARRY_W + 1)'(r_top) + (CARRY_W + 1)'(w_link[DIGITS].carry);
    assign w_dig[DIGITS].vld   = w_link[DIGITS].act;
    assign w_dig[DIGITS].digit = w_top_sum[DIGIT_BITS-1:0];

    for (genvar j = 0; j < DIGITS; j++) begin : g_cell
        if (j == 0) begin : g_low
            mmc_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_load  (w_accept),
                .i_a     (w_a_ext[j*DIGIT_BITS +: DIGIT_BITS]),
                .i_n     (w_n_ext[j*DIGIT_BITS +: DIGIT_BITS]),
                .i_b     (r_b[DIGIT_BITS-1:0]),
                .i_m     (r_m),
                .i_link  (w_link[j]),
                .o_link  (w_link[j+1]),
                .i_dig   (w_dig[j+1]),
                .o_dig   (),
                .o_t     (w_t[j])
            );
        end else begin : g_mid
            mmc_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_load  (w_accept),
                .i_a     (w_a_ext[j*DIGIT_BITS +: DIGIT_BITS]),
                .i_n     (w_n_ext[j*DIGIT_BITS +: DIGIT_BITS]),
                .i_b     (r_b[DIGIT_BITS-1:0]),
                .i_m     (r_m),
                .i_link  (w_link[j]),
                .o_link  (w_link[j+1]),
                .i_dig   (w_dig[j+1]),
                .o_dig   (w_dig[j]),
                .o_t     (w_t[j])
            );
        end
        assign w_t_flat[j*DIGIT_BITS +: DIGIT_BITS] = w_t[j];
    end

    for (genvar k = 0; k <= DIGITS; k++) begin : g_act
        assign w_act[k] = w_link[k].act;
    end

    // ------------------------------------------------------------------
    // Final conditional subtraction: t >= n gives t - n
    // ------------------------------------------------------------------
    localparam int FULL_W = VAL_W + CARRY_W;

    logic [FULL_W-1:0] w_tval;
    logic [FULL_W-1:0] w_nval;
    logic [FULL_W-1:0] w_diff;
    logic [FULL_W-1:0] w_res;

    assign w_tval = {r_top, w_t_flat};
    assign w_nval = FULL_W'(w_n_ext);
    assign w_diff = w_tval - w_nval;
    assign w_res  = (w_tval >= w_nval) ? w_diff : w_tval;

    // ------------------------------------------------------------------
    // Sequencer: one pass per digit of b, DIGITS+1 steps per pass
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // raise the result word when a product lands, drop it once taken
            if (r_state == S_FIN && (!r_out_valid || o_out.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_step  <= '0;
                    r_iter  <= '0;
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    if (r_step == STEP_W'(DIGITS)) begin
                        r_step <= '0;
                        if (r_iter == ITER_W'(DIGITS - 1)) begin
                            r_state <= S_FIN;
                        end else begin
                            r_iter <= r_iter + ITER_W'(1);
                        end
                    end else begin
                        r_step <= r_step + STEP_W'(1);
                    end
                end
                S_FIN: begin
                    // hold until the output register is free
                    if (!r_out_valid || o_out.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers of the sequencer
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_b   <= w_b_ext;
            r_an  <= DIGIT_BITS'(w_an_prod);
            r_top <= '0;
        end else begin
            if (w_link[DIGITS].act) begin
                r_top <= CARRY_W'(w_top_sum >> DIGIT_BITS);
            end
            if (r_state == S_PREP) begin
                r_m <= calc_m(w_t[0], w_nd, r_an, r_b[DIGIT_BITS-1:0]);
            end else if (r_state == S_RUN && r_step == STEP_W'(DIGITS)) begin
                // t0 of the next pass has been stable since step 2; advance b
                r_m <= calc_m(w_t[0], w_nd, r_an, r_b[2*DIGIT_BITS-1:DIGIT_BITS]);
                r_b <= r_b >> DIGIT_BITS;
            end
        end
        if (r_state == S_FIN && (!r_out_valid || o_out.ready)) begin
            r_product <= DATA_W'(w_res);
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_single_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_act))
        else $error("more than one cell active in the chain");

    a_token_at_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && r_step == STEP_W'(DIGITS)) |-> w_link[DIGITS].act)
        else $error("token did not reach the top digit on the last step");

    a_accept_to_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_PREP))
        else $error("accepted word did not start a computation");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_FIN))
        else $error("result word raised outside the final step");

endmodule

### hw/rtl/mmc_cell.sv
// ============================================================================
// mmc_cell: one digit cell of the CIOS chain
// Holds one digit of a, n and the running sum t. When the token arrives it
// adds a*b_i + m*n_j and the incoming carry, passes the carry up and the
// low digit down to its lower neighbor.
// ============================================================================
module mmc_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  mmc_pkg::t_digit i_a,
    input  mmc_pkg::t_digit i_n,
    input  mmc_pkg::t_digit i_b,
    input  mmc_pkg::t_digit i_m,
    input  mmc_pkg::t_link  i_link,
    output mmc_pkg::t_link  o_link,
    input  mmc_pkg::t_dig   i_dig,
    output mmc_pkg::t_dig   o_dig,
    output mmc_pkg::t_digit o_t
);
    import mmc_pkg::*;

    t_digit             r_a;
    t_digit             r_n;
    t_digit             r_t;
    t_link              r_link;
    logic [PROD_W-1:0]  w_ab;
    logic [PROD_W-1:0]  w_mn;
    logic [SUM_W-1:0]   w_sum;

    assign w_ab  = PROD_W'(r_a) * PROD_W'(i_b);
    assign w_mn  = PROD_W'(i_m) * PROD_W'(r_n);
    assign w_sum = SUM_W'(r_t) + SUM_W'(w_ab) + SUM_W'(w_mn) + SUM_W'(i_link.carry);

    assign o_dig.vld   = i_link.act;
    assign o_dig.digit = w_sum[DIGIT_BITS-1:0];
    assign o_link      = r_link;
    assign o_t         = r_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link <= '0;
        end else if (i_load) begin
            r_link <= '0;
        end else begin
            r_link.act   <= i_link.act;
            r_link.carry <= w_sum[SUM_W-1:DIGIT_BITS];
        end
    end

    // digit payload: load operands, clear sum, take shifted digit
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_a <= i_a;
            r_n <= i_n;
            r_t <= '0;
        end else if (i_dig.vld) begin
            r_t <= i_dig.digit;
        end
    end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb: self-checking bench for montgomery_multiply_cios_top
// Starts with a short table of operand words under the reset settings, then
// walks a plan of modulus settings (unit, small, top bit, all ones, zero,
// even, bad n') with random operand words. Each product word is checked
// against a typed value or a word-level CIOS predictor. Random stalls on
// both channels, one long back-pressure stretch, a final stretch with no idling.
// ============================================================================
module tb;
    import mmc_pkg::*;

    localparam int          RESET_CYCLES      = 4;
    localparam int          NUM_DIRECTED      = 20;
    localparam int          NUM_SETTINGS      = 12;
    localparam int          ITEMS_PER_SETTING = 105;
    localparam int          HOLD_SETTING      = 8;     // long receiver hold here
    localparam int          DRAIN_SETTING     = 9;     // sender pauses mid-way here
    localparam int          HOLD_CYCLES       = 600;
    localparam int          TAIL_CYCLES       = 150;
    localparam int unsigned CYCLE_LIMIT       = 1000000;
    localparam int          MAX_REPORTS       = 10;

    localparam logic [DATA_W-1:0]    MODULUS_AT_RESET   = '1;
    localparam t_digit               N_PRIME_AT_RESET   = 1;
    localparam logic [CFG_IDX_W-1:0] IDX_FIRST_UNMAPPED = 2;
    localparam logic [CFG_IDX_W-1:0] IDX_LAST_UNMAPPED  = '1;

    typedef enum {
        SET_UNIT,
        SET_THREE,
        SET_HIGH_BIT,
        SET_ALL_ONES,
        SET_ZERO,
        SET_EVEN,
        SET_BAD_INVERSE,
        SET_RANDOM_ODD
    } t_setting;

    // one operand word of the directed table; product is typed in only
    // where it can be read off directly
    typedef struct packed {
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic              typed;
        logic [DATA_W-1:0] product;
    } t_row;

    // one product word still owed by the block
    typedef struct packed {
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] product;
    } t_owed;

    logic i_clk;
    logic i_rst_n;

    mmc_in_if  in_ch ();
    mmc_out_if out_ch ();
    mmc_cfg_if cfg_ch ();

    montgomery_multiply_cios_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Shadow of the two configuration registers, as the predictor sees them.
    logic [DATA_W-1:0] modulus_model;
    t_digit            n_prime_model;

    t_owed       products_owed [$];
    int unsigned mismatches      = 0;
    int unsigned products_seen   = 0;
    int unsigned words_sent      = 0;
    int unsigned settings_loaded = 0;
    int unsigned holds_asked     = 0;
    int unsigned sender_calm     = 0;
    logic        no_gaps         = 1'b0;

    // Reset settings are n = 2^32-1 and n' = 1, so R = 2^32 is 1 mod n and
    // the Montgomery product collapses to a*b mod n for operands below n.
    t_row directed_rows [NUM_DIRECTED] = '{
        '{32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
        '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{32'h0000_0001, 32'h0000_0001, 1'b1, 32'h0000_0001},
        '{32'h0000_0002, 32'h0000_0003, 1'b1, 32'h0000_0006},
        '{32'hFFFF_FFFE, 32'h0000_0001, 1'b1, 32'hFFFF_FFFE},
        '{32'h0000_0001, 32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFE},
        '{32'hFFFF_FFFE, 32'hFFFF_FFFE, 1'b1, 32'h0000_0001},
        '{32'h8000_0000, 32'h8000_0000, 1'b1, 32'h4000_0000},
        '{32'h0000_0001, 32'h8000_0000, 1'b1, 32'h8000_0000},
        '{32'h1234_5678, 32'h0000_0001, 1'b1, 32'h1234_5678},
        '{32'h0000_000F, 32'h0000_0010, 1'b1, 32'h0000_00F0},
        '{32'h7FFF_FFFF, 32'h0000_0002, 1'b1, 32'hFFFF_FFFE},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
        '{32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 32'h0000_0000},
        '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 32'h0000_0000},
        '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 32'h0000_0000},
        '{32'hFFFF_0000, 32'h0000_FFFF, 1'b0, 32'h0000_0000},
        '{32'h0F0F_0F0F, 32'hF0F0_F0F0, 1'b0, 32'h0000_0000},
        '{32'h3C3C_3C3C, 32'hC3C3_C3C3, 1'b0, 32'h0000_0000}
    };

    // Settings plan: extremes first, then the broken cases, then plain odd
    // moduli with a correct n'. The last entry runs with no idling.
    t_setting setting_plan [NUM_SETTINGS] = '{
        SET_UNIT, SET_THREE, SET_HIGH_BIT, SET_ALL_ONES, SET_ZERO, SET_EVEN,
        SET_BAD_INVERSE, SET_RANDOM_ODD, SET_RANDOM_ODD, SET_RANDOM_ODD,
        SET_RANDOM_ODD, SET_RANDOM_ODD
    };

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor: CIOS with the running sum kept as one wide value. Adding
    // a*b[i], then m*n, then dropping one digit is the same as the digit
    // loop with its carries, whatever n and n' are. The sum stays below
    // 2^37, so 40 bits hold it.
    // ------------------------------------------------------------------------
    function automatic logic [DATA_W-1:0] cios_product(input logic [DATA_W-1:0] a,
                                                      input logic [DATA_W-1:0] b,
                                                      input logic [DATA_W-1:0] n,
                                                      input t_digit n_prime);
        logic [DATA_W+7:0] acc;
        t_digit            b_dig;
        t_digit            m_dig;
        acc = '0;
        for (int i = 0; i < DIGITS; i++) begin
            b_dig = b[i*DIGIT_BITS +: DIGIT_BITS];
            acc   = acc + a * b_dig;
            // low digit times n', kept to one digit
            m_dig = acc[DIGIT_BITS-1:0] * n_prime;
            acc   = (acc + n * m_dig) >> DIGIT_BITS;
        end
        // single conditional subtraction; a zero modulus leaves the sum as is
        if (acc >= n)
            acc = acc - n;
        return acc[DATA_W-1:0];
    endfunction

    // n' = -n^-1 mod 2^w, found by trying every digit (n must be odd)
    function automatic t_digit neg_inverse_digit(input logic [DATA_W-1:0] n);
        t_digit guess;
        t_digit low;
        for (int x = 0; x < (1 << DIGIT_BITS); x++) begin
            guess = t_digit'(x);
            low   = n[DIGIT_BITS-1:0] * guess + 1'b1;
            if (low == '0)
                return guess;
        end
        return '0;
    endfunction

    // Mostly operands below n, with extremes and out-of-range values mixed in.
    function automatic logic [DATA_W-1:0] pick_operand(input logic [DATA_W-1:0] n);
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return n - 1'b1;
            2:       return '1;
            3:       return $urandom();
            4:       return 32'd1 << $urandom_range(0, DATA_W - 1);
            default: return (n == '0) ? $urandom() : $urandom() % n;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Configuration channel
    // ------------------------------------------------------------------------
    // Offer one register word, hold it until taken, then mirror the write.
    // Valid stays high so back-to-back writes do not toggle it in one step.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [DATA_W-1:0]    value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            REG_MODULUS:     modulus_model = value;
            REG_MOD_INV_DIG: n_prime_model = value[DIGIT_BITS-1:0];
            default: ;      // unmapped index: the block must ignore it
        endcase
    endtask

    task automatic load_settings(input logic [DATA_W-1:0]    modulus,
                                 input logic [DATA_W-1:0]    n_prime_word,
                                 input logic [CFG_IDX_W-1:0] stray_idx);
        write_register(REG_MODULUS, modulus);
        write_register(REG_MOD_INV_DIG, n_prime_word);
        write_register(stray_idx, $urandom());
        cfg_ch.valid <= 1'b0;
        settings_loaded++;
    endtask

    // ------------------------------------------------------------------------
    // Operand channel
    // ------------------------------------------------------------------------
    // Idle the sender now and then: short bursts, sometimes a string of them
    // so acceptance slides across the block's whole turn, and calm stretches
    // with no idling at all.
    task automatic sender_gap();
        int unsigned bursts;
        bursts = 0;
        if (no_gaps)
            return;
        if (sender_calm != 0) begin
            sender_calm--;
            return;
        end
        if ($urandom_range(0, 19) == 0)
            bursts = $urandom_range(2, 10);
        else if ($urandom_range(0, 2) == 0)
            bursts = 1;
        if ($urandom_range(0, 15) == 0)
            sender_calm = $urandom_range(10, 40);
        if (bursts != 0) begin
            in_ch.valid <= 1'b0;
            repeat (bursts)
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    // Offer one operand word, wait for it to be taken, then record the
    // product it owes: the typed one for table rows that carry it, else
    // the predictor's.
    task automatic send_operands(input logic [DATA_W-1:0] a,
                                 input logic [DATA_W-1:0] b,
                                 input logic              typed,
                                 input logic [DATA_W-1:0] typed_product);
        t_owed owed;
        in_ch.valid   <= 1'b1;
        in_ch.a_value <= a;
        in_ch.b_value <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        owed.a       = a;
        owed.b       = b;
        owed.product = typed ? typed_product
                             : cios_product(a, b, modulus_model, n_prime_model);
        products_owed.push_back(owed);
        words_sent++;
        sender_gap();
    endtask

    // Drop valid and wait until every owed product word has come back.
    task automatic drain_products();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (products_owed.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Product channel: check what arrived, then decide ready for next cycle
    // ------------------------------------------------------------------------
    task automatic check_product(input logic [DATA_W-1:0] got);
        t_owed owed;
        if (products_owed.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: product word %h arrived with nothing owed", $realtime, got);
        end else begin
            owed = products_owed.pop_front();
            products_seen++;
            if (got !== owed.product) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: product for a=%h b=%h: expected %h, got %h",
                             $realtime, owed.a, owed.b, owed.product, got);
            end
        end
    endtask

    initial begin : product_sink
        int unsigned stall_left;
        int unsigned calm_left;
        int unsigned hold_left;
        int unsigned holds_served;
        stall_left   = 0;
        calm_left    = 0;
        hold_left    = 0;
        holds_served = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready)
                check_product(out_ch.product);
            // a fresh hold request starts the long back-pressure stretch
            if (holds_served != holds_asked) begin
                holds_served = holds_asked;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (!no_gaps && calm_left == 0 && $urandom_range(0, 5) == 0) begin
                // start a stall burst, this cycle included
                stall_left   = $urandom_range(0, 7);
                out_ch.ready <= 1'b0;
                if ($urandom_range(0, 7) == 0)
                    calm_left = $urandom_range(100, 400);
            end else begin
                if (calm_left != 0)
                    calm_left--;
                out_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: count cycles, fail the run if it never finishes
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("stopped after %0d cycles, %0d product words still owed",
                 CYCLE_LIMIT, products_owed.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [DATA_W-1:0]    mod_word;
        logic [DATA_W-1:0]    n_prime_word;
        logic [CFG_IDX_W-1:0] stray_idx;
        t_digit               n_prime;
        t_setting             kind;

        // hold every input at a known value through reset
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.a_value = '0;
        in_ch.b_value = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = '0;
        cfg_ch.data   = '0;
        modulus_model = MODULUS_AT_RESET;
        n_prime_model = N_PRIME_AT_RESET;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table under the reset settings
        foreach (directed_rows[r])
            send_operands(directed_rows[r].a, directed_rows[r].b,
                          directed_rows[r].typed, directed_rows[r].product);

        for (int p = 0; p < NUM_SETTINGS; p++) begin
            kind = setting_plan[p];
            // registers change only with the block empty
            drain_products();

            case (kind)
                SET_UNIT:     mod_word = 32'd1;
                SET_THREE:    mod_word = 32'd3;
                SET_HIGH_BIT: mod_word = 32'h8000_0001;
                SET_ALL_ONES: mod_word = '1;
                SET_ZERO:     mod_word = '0;
                SET_EVEN:     mod_word = ($urandom() | 32'd2) & ~32'd1;
                default:      mod_word = $urandom() | 32'd1;
            endcase
            n_prime = neg_inverse_digit(mod_word);
            // even or zero modulus has no inverse: any n' will do
            if (kind == SET_ZERO || kind == SET_EVEN)
                n_prime = t_digit'($urandom());
            if (kind == SET_BAD_INVERSE)
                n_prime = n_prime ^ t_digit'($urandom_range(1, (1 << DIGIT_BITS) - 1));
            // junk above the digit must be masked off by the block
            n_prime_word = ($urandom() << NDI_W) | DATA_W'(n_prime);

            if (p == 0)
                stray_idx = IDX_FIRST_UNMAPPED;
            else if (p == 1)
                stray_idx = IDX_LAST_UNMAPPED;
            else
                stray_idx = CFG_IDX_W'($urandom_range(IDX_FIRST_UNMAPPED, IDX_LAST_UNMAPPED));

            // last setting runs flat out on both sides
            if (p == NUM_SETTINGS - 1)
                no_gaps <= 1'b1;
            load_settings(mod_word, n_prime_word, stray_idx);

            // receiver holds off while the sender keeps offering words
            if (p == HOLD_SETTING)
                holds_asked <= holds_asked + 1;

            for (int k = 0; k < ITEMS_PER_SETTING; k++) begin
                if (p == DRAIN_SETTING && k == ITEMS_PER_SETTING / 2)
                    drain_products();
                send_operands(pick_operand(mod_word), pick_operand(mod_word), 1'b0, '0);
            end
        end

        drain_products();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d operand words across %0d register settings plus reset values;",
                 words_sent, settings_loaded);
        $display("compared %0d product words, %0d mismatches.", products_seen, mismatches);
        if (mismatches == 0 && products_owed.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### sim.f
hw/rtl/mmc_pkg.sv
hw/rtl/mmc_if.sv
hw/rtl/mmc_cell.sv
hw/rtl/montgomery_multiply_cios_top.sv
tb/sv/tb.sv
